// File: rtl/infix_to_postfix_converter_core_macros.svh
// ----------------------------------------------------------------------------
// infix to postfix converter assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef INFIX_TO_POSTFIX_CONVERTER_CORE_MACROS_SVH
`define INFIX_TO_POSTFIX_CONVERTER_CORE_MACROS_SVH

// same-cycle implication, quiet while in reset
`define I2P_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, quiet while in reset
`define I2P_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/i2p_pkg.sv
// ----------------------------------------------------------------------------
// i2p_pkg
// types, codes and helpers shared by the infix to postfix converter
// ----------------------------------------------------------------------------
package i2p_pkg;

  // operator stack geometry
  localparam int STACK_DEPTH = 16;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = $clog2(STACK_DEPTH);

  // command queue between front and back
  localparam int CQ_DEPTH = 2;
  localparam int CQ_PTR_W = (CQ_DEPTH > 1) ? $clog2(CQ_DEPTH) : 1;
  localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

  // characters
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;

  // stacked operator codes
  typedef logic [2:0] op_code_t;
  localparam op_code_t OP_NONE = 3'd0;
  localparam op_code_t OP_ADD  = 3'd1;
  localparam op_code_t OP_SUB  = 3'd2;
  localparam op_code_t OP_MUL  = 3'd3;
  localparam op_code_t OP_DIV  = 3'd4;
  localparam op_code_t OP_LP   = 3'd5;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNMATCHED = 2'd2;
  localparam logic [1:0] ST_UNKNOWN   = 2'd3;

  typedef struct packed {
    logic [7:0] in_char;
    logic       end_mark;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic       last_of_expr;
    logic [1:0] status;
  } out_item_t;

  typedef enum logic [2:0] {
    K_DIGIT   = 3'd0,
    K_OP      = 3'd1,
    K_LPAREN  = 3'd2,
    K_RPAREN  = 3'd3,
    K_END     = 3'd4,
    K_UNKNOWN = 3'd5
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] ch;
    op_code_t   code;
  } cmd_t;

  function automatic logic [1:0] op_prec(input op_code_t code);
    logic [1:0] p;
    case (code)
      OP_MUL, OP_DIV: p = 2'd2;
      OP_ADD, OP_SUB: p = 2'd1;
      default:        p = 2'd0;
    endcase
    return p;
  endfunction

  function automatic logic [7:0] op_char(input op_code_t code);
    logic [7:0] c;
    case (code)
      OP_ADD:  c = CH_PLUS;
      OP_SUB:  c = CH_MINUS;
      OP_MUL:  c = CH_STAR;
      OP_DIV:  c = CH_SLASH;
      OP_LP:   c = CH_LPAREN;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/i2p_front.sv
// ----------------------------------------------------------------------------
// i2p_front
// accepts characters, decodes them into commands and queues them
// ----------------------------------------------------------------------------
module i2p_front
  import i2p_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     full,
  input  in_item_t item,
  output logic     cmd_valid,
  output cmd_t     cmd,
  input  logic     cmd_take
);

  cmd_t                cmd_in;
  cmd_t                cq_mem [CQ_DEPTH];
  logic [CQ_PTR_W-1:0] wr_ptr;
  logic [CQ_PTR_W-1:0] rd_ptr;
  logic [CQ_CNT_W-1:0] cq_count;
  logic                wr_en;
  logic                rd_en;

  // character decode
  always_comb begin
    cmd_in.kind = K_UNKNOWN;
    cmd_in.ch   = '0;
    cmd_in.code = OP_NONE;
    if (item.end_mark) begin
      cmd_in.kind = K_END;
    end else if (item.in_char >= CH_ZERO && item.in_char <= CH_NINE) begin
      cmd_in.kind = K_DIGIT;
      cmd_in.ch   = item.in_char;
    end else begin
      unique case (item.in_char)
        CH_PLUS:   begin cmd_in.kind = K_OP;     cmd_in.code = OP_ADD; end
        CH_MINUS:  begin cmd_in.kind = K_OP;     cmd_in.code = OP_SUB; end
        CH_STAR:   begin cmd_in.kind = K_OP;     cmd_in.code = OP_MUL; end
        CH_SLASH:  begin cmd_in.kind = K_OP;     cmd_in.code = OP_DIV; end
        CH_LPAREN: begin cmd_in.kind = K_LPAREN; cmd_in.code = OP_LP;  end
        CH_RPAREN: cmd_in.kind = K_RPAREN;
        default:   cmd_in.kind = K_UNKNOWN;
      endcase
    end
  end

  assign full      = cq_count == CQ_CNT_W'(CQ_DEPTH);
  assign cmd_valid = cq_count != '0;
  assign cmd       = cq_mem[rd_ptr];
  assign wr_en     = push && !full;
  assign rd_en     = cmd_take && cmd_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      cq_mem[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      cq_count <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        cq_count <= cq_count + 1'b1;
      end else if (rd_en && !wr_en) begin
        cq_count <= cq_count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/i2p_back.sv
// ----------------------------------------------------------------------------
// i2p_back
// operator stack sequencer, one stack step per cycle unless the result slot is busy, with result register
// ----------------------------------------------------------------------------
module i2p_back
  import i2p_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  input  cmd_t      cmd,
  output logic      cmd_take,
  input  logic      pop,
  output logic      empty,
  output out_item_t result
);

  // stack memory plus cached top and second entries
  op_code_t         op_mem [STACK_DEPTH];
  op_code_t         top;
  op_code_t         below;
  logic [CNT_W-1:0] count;

  logic      out_valid;
  out_item_t res;
  logic      want_emit;
  logic      want_pop;
  logic      want_push;
  logic      want_done;
  logic      fire;
  logic      slot_free;
  logic      has_top;
  logic      stack_full;
  logic      top_is_last;

  assign has_top     = count != '0;
  assign stack_full  = count == CNT_W'(STACK_DEPTH);
  assign top_is_last = count == CNT_W'(1);
  assign slot_free   = !out_valid || pop;

  always_comb begin
    res       = '0;
    want_emit = 1'b0;
    want_pop  = 1'b0;
    want_push = 1'b0;
    want_done = 1'b0;
    unique case (cmd.kind)
      K_DIGIT: begin
        want_emit      = 1'b1;
        want_done      = 1'b1;
        res.out_char   = cmd.ch;
        res.char_valid = 1'b1;
      end
      K_UNKNOWN: begin
        want_emit  = 1'b1;
        want_done  = 1'b1;
        res.status = ST_UNKNOWN;
      end
      K_OP, K_LPAREN: begin
        // pop while top binds at least as tightly (left associative)
        if (cmd.kind == K_OP && has_top && top != OP_LP &&
            op_prec(top) >= op_prec(cmd.code)) begin
          want_pop       = 1'b1;
          want_emit      = 1'b1;
          res.out_char   = op_char(top);
          res.char_valid = 1'b1;
        end else if (stack_full) begin
          want_emit  = 1'b1;
          want_done  = 1'b1;
          res.status = ST_OVERFLOW;
        end else begin
          want_push = 1'b1;
          want_done = 1'b1;
        end
      end
      K_RPAREN: begin
        if (!has_top) begin
          want_emit  = 1'b1;
          want_done  = 1'b1;
          res.status = ST_UNMATCHED;
        end else if (top == OP_LP) begin
          want_pop  = 1'b1;
          want_done = 1'b1;
        end else begin
          // pop an operator on the way to the open paren; the last entry means none was stacked
          want_pop       = 1'b1;
          want_emit      = 1'b1;
          want_done      = top_is_last;
          res.out_char   = op_char(top);
          res.char_valid = 1'b1;
          res.status     = top_is_last ? ST_UNMATCHED : ST_OK;
        end
      end
      K_END: begin
        want_emit = 1'b1;
        if (!has_top) begin
          want_done        = 1'b1;
          res.last_of_expr = 1'b1;
        end else begin
          want_pop         = 1'b1;
          want_done        = top_is_last;
          res.last_of_expr = top_is_last;
          if (top == OP_LP) begin
            res.status = ST_UNMATCHED;
          end else begin
            res.out_char   = op_char(top);
            res.char_valid = 1'b1;
          end
        end
      end
      default: begin
        want_done = 1'b1;
      end
    endcase
  end

  assign fire     = cmd_valid && (!want_emit || slot_free);
  assign cmd_take = fire && want_done;

  // stack storage and cached entries
  always_ff @(posedge clk) begin
    if (fire && want_push) begin
      op_mem[count[IDX_W-1:0]] <= cmd.code;
      top                      <= cmd.code;
      below                    <= top;
    end else if (fire && want_pop) begin
      top <= below;
      if (count >= CNT_W'(3)) begin
        below <= op_mem[IDX_W'(count - CNT_W'(3))];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (fire && want_push) begin
      count <= count + 1'b1;
    end else if (fire && want_pop) begin
      count <= count - 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (fire && want_emit) begin
      result <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && want_emit) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  assign empty = !out_valid;

endmodule

// File: rtl/infix_to_postfix_converter_core.sv
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_core
// shunting-yard infix to postfix conversion, one character per request
// ----------------------------------------------------------------------------
// Takes one infix character per request (or an end marker) and returns the
// postfix characters and status results in order. A front stage decodes each
// character into a command and holds up to two commands in a queue; the back
// stage runs the operator stack into a one-entry result register, one stack
// step per cycle while that register can take what the step emits. Digits,
// unknown characters, pushes and a paren match each take one back-end step;
// every operator popped by precedence, by ')' or by the end marker takes one
// more step. A plain digit stream therefore runs at one request per cycle
// while the receiver pops each result. The bound is the single stack port:
// one write or one pop a cycle, with the entry under the top cached and
// refilled from the stack memory on each pop. There is no clearing pass after
// reset; the stack is tracked by its fill count alone.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_core
  import i2p_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  // request side
  input  logic      push,
  output logic      full,
  input  in_item_t  item,
  // result side
  output logic      empty,
  input  logic      pop,
  output out_item_t result
);

  // decoded command handoff between front and back
  logic cmd_valid;
  cmd_t cmd;
  logic cmd_take;

  // front: decode and short command queue
  i2p_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  // back: operator stack sequencer and result register
  i2p_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .pop       (pop),
    .empty     (empty),
    .result    (result)
  );

endmodule

// File: rtl/i2p_checker.sv
// ----------------------------------------------------------------------------
// i2p_checker
// port-level checks of the result stream
// ----------------------------------------------------------------------------
`include "infix_to_postfix_converter_core_macros.svh"

module i2p_checker
  import i2p_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      empty,
  input logic      pop,
  input out_item_t result
);

  // status allowed on a character or on the end of a flush
  logic status_ok;
  assign status_ok = result.status == ST_OK || result.status == ST_UNMATCHED;

  // a waiting result stays put until taken
  `I2P_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(result), "held result changed")

  // status-only results carry a zero character
  `I2P_ASSERT_NOW(a_no_char, !empty && !result.char_valid, result.out_char == 8'h00, "stray char")

  // emitted characters never carry overflow or unknown status
  `I2P_ASSERT_NOW(a_char_status, !empty && result.char_valid, status_ok, "bad status on char")

  // the end of a flush is never an overflow or unknown report
  `I2P_ASSERT_NOW(a_last_status, !empty && result.last_of_expr, status_ok, "bad status on last")

endmodule

bind infix_to_postfix_converter_core i2p_checker u_i2p_checker (
  .clk    (clk),
  .rst    (rst),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the infix to postfix converter core
// ----------------------------------------------------------------------------
// Sends a short hand-written expression table, then random expressions,
// deep nesting and noise, as requests. A shunting-yard predictor runs on each
// accepted request and queues its postfix results (hand-typed rows queue their
// own). Each popped result is checked field by field against the oldest.
// ----------------------------------------------------------------------------
module testbench;
  import i2p_pkg::*;

  localparam int N_DIRECTED  = 25;
  localparam int N_ITEMS     = 480;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT = 200000;

  // one stimulus row: the request, and a hand-typed result where it is obvious
  typedef struct packed {
    in_item_t  req;
    logic      by_hand;
    out_item_t want;
  } stim_row_t;

  localparam logic       BY_HAND      = 1'b1;
  localparam logic       BY_PREDICTOR = 1'b0;
  localparam out_item_t  PREDICTED    = '0;
  localparam logic [7:0] NO_CHAR      = 8'h00;
  localparam logic [3:0][7:0] OP_CHARS = {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};

  // directed rows, walked in order before the random part
  localparam stim_row_t [0:N_DIRECTED-1] DIRECTED = {
    // end mark on an empty stack, character bits all ones and ignored
    {8'hFF,     1'b1, BY_HAND, NO_CHAR, 1'b0, 1'b1, ST_OK},
    // close paren with nothing stacked
    {CH_RPAREN, 1'b0, BY_HAND, NO_CHAR, 1'b0, 1'b0, ST_UNMATCHED},
    // unknown characters: both ends of the byte range and a space
    {8'h00,     1'b0, BY_HAND, NO_CHAR, 1'b0, 1'b0, ST_UNKNOWN},
    {8'hFF,     1'b0, BY_HAND, NO_CHAR, 1'b0, 1'b0, ST_UNKNOWN},
    {" ",       1'b0, BY_HAND, NO_CHAR, 1'b0, 1'b0, ST_UNKNOWN},
    // lowest and highest digit
    {CH_ZERO,   1'b0, BY_HAND, CH_ZERO, 1'b1, 1'b0, ST_OK},
    {CH_NINE,   1'b0, BY_HAND, CH_NINE, 1'b1, 1'b0, ST_OK},
    // (1+2*3-4/5): '-' pops '*' and then the equal-rank '+'
    {CH_LPAREN, 1'b0, BY_PREDICTOR, PREDICTED},
    {"1",       1'b0, BY_PREDICTOR, PREDICTED},
    {CH_PLUS,   1'b0, BY_PREDICTOR, PREDICTED},
    {"2",       1'b0, BY_PREDICTOR, PREDICTED},
    {CH_STAR,   1'b0, BY_PREDICTOR, PREDICTED},
    {"3",       1'b0, BY_PREDICTOR, PREDICTED},
    {CH_MINUS,  1'b0, BY_PREDICTOR, PREDICTED},
    {"4",       1'b0, BY_PREDICTOR, PREDICTED},
    {CH_SLASH,  1'b0, BY_PREDICTOR, PREDICTED},
    {"5",       1'b0, BY_PREDICTOR, PREDICTED},
    {CH_RPAREN, 1'b0, BY_PREDICTOR, PREDICTED},
    // 6+7) : close paren without an open one, the popped '+' is flagged
    {"6",       1'b0, BY_PREDICTOR, PREDICTED},
    {CH_PLUS,   1'b0, BY_PREDICTOR, PREDICTED},
    {"7",       1'b0, BY_PREDICTOR, PREDICTED},
    {CH_RPAREN, 1'b0, BY_PREDICTOR, PREDICTED},
    // "(*" then end: '*' comes out, the leftover '(' is flagged on the last one
    {CH_LPAREN, 1'b0, BY_PREDICTOR, PREDICTED},
    {CH_STAR,   1'b0, BY_PREDICTOR, PREDICTED},
    {8'h00,     1'b1, BY_PREDICTOR, PREDICTED}
  };

  logic      clk  = 1'b0;
  logic      rst  = 1'b1;
  logic      push = 1'b0;
  logic      pop  = 1'b0;
  in_item_t  item = '0;
  logic      full;
  logic      empty;
  out_item_t result;

  stim_row_t   stim_q [$];
  out_item_t   postfix_q [$];   // results still owed by the block, oldest first
  out_item_t   step_res [$];    // results of the latest predictor step
  op_code_t    shunt_stk [STACK_DEPTH];
  int unsigned shunt_cnt  = 0;
  int unsigned acc_idx    = 0;
  int unsigned phase      = 0;  // 0: sender idles less, 1: receiver idles less, 2: none
  int unsigned mismatches = 0;
  int unsigned cycle_cnt  = 0;
  stim_row_t   accepted;
  out_item_t   want;

  infix_to_postfix_converter_core dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // shunting-yard predictor
  // ---------------------------------------------------------------------------

  function automatic int unsigned op_rank(input op_code_t c);
    if (c == OP_MUL || c == OP_DIV) return 2;
    if (c == OP_ADD || c == OP_SUB) return 1;
    return 0;
  endfunction

  function automatic logic [7:0] op_symbol(input op_code_t c);
    case (c)
      OP_ADD:  return CH_PLUS;
      OP_SUB:  return CH_MINUS;
      OP_MUL:  return CH_STAR;
      OP_DIV:  return CH_SLASH;
      default: return NO_CHAR;
    endcase
  endfunction

  function automatic void emit_res(input logic [7:0] ch, input logic valid,
                                   input logic last, input logic [1:0] st);
    out_item_t r;
    r.out_char     = ch;
    r.char_valid   = valid;
    r.last_of_expr = last;
    r.status       = st;
    step_res.push_back(r);
  endfunction

  // one request through the operator stack, results land in step_res
  function automatic void shunt_step(input in_item_t req);
    op_code_t  code;
    op_code_t  top;
    bit        matched;
    out_item_t tail;
    step_res.delete();
    if (req.end_mark) begin
      // flush top first, the final result carries last_of_expr
      if (shunt_cnt == 0) emit_res(NO_CHAR, 1'b0, 1'b1, ST_OK);
      while (shunt_cnt > 0) begin
        shunt_cnt--;
        top = shunt_stk[shunt_cnt];
        if (top == OP_LP) emit_res(NO_CHAR, 1'b0, shunt_cnt == 0, ST_UNMATCHED);
        else emit_res(op_symbol(top), 1'b1, shunt_cnt == 0, ST_OK);
      end
    end else if (req.in_char >= CH_ZERO && req.in_char <= CH_NINE) begin
      emit_res(req.in_char, 1'b1, 1'b0, ST_OK);
    end else if (req.in_char == CH_PLUS || req.in_char == CH_MINUS ||
                 req.in_char == CH_STAR || req.in_char == CH_SLASH ||
                 req.in_char == CH_LPAREN) begin
      case (req.in_char)
        CH_PLUS:  code = OP_ADD;
        CH_MINUS: code = OP_SUB;
        CH_STAR:  code = OP_MUL;
        CH_SLASH: code = OP_DIV;
        default:  code = OP_LP;
      endcase
      // left associative: pop equal or higher rank down to an open paren
      if (code != OP_LP) begin
        while (shunt_cnt > 0 && shunt_stk[shunt_cnt - 1] != OP_LP &&
               op_rank(shunt_stk[shunt_cnt - 1]) >= op_rank(code)) begin
          shunt_cnt--;
          emit_res(op_symbol(shunt_stk[shunt_cnt]), 1'b1, 1'b0, ST_OK);
        end
      end
      if (shunt_cnt >= STACK_DEPTH) begin
        emit_res(NO_CHAR, 1'b0, 1'b0, ST_OVERFLOW);
      end else begin
        shunt_stk[shunt_cnt] = code;
        shunt_cnt++;
      end
    end else if (req.in_char == CH_RPAREN) begin
      matched = 1'b0;
      while (shunt_cnt > 0 && !matched) begin
        shunt_cnt--;
        top = shunt_stk[shunt_cnt];
        if (top == OP_LP) matched = 1'b1;
        else emit_res(op_symbol(top), 1'b1, 1'b0, ST_OK);
      end
      // no open paren found: flag the last popped operator, or report alone
      if (!matched) begin
        if (step_res.size() == 0) begin
          emit_res(NO_CHAR, 1'b0, 1'b0, ST_UNMATCHED);
        end else begin
          tail = step_res.pop_back();
          tail.status = ST_UNMATCHED;
          step_res.push_back(tail);
        end
      end
    end else begin
      emit_res(NO_CHAR, 1'b0, 1'b0, ST_UNKNOWN);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic void add_char(input logic [7:0] ch);
    stim_q.push_back(stim_row_t'({ch, 1'b0, BY_PREDICTOR, PREDICTED}));
  endfunction

  // end mark with a random character that the block must ignore
  function automatic void add_end();
    stim_q.push_back(stim_row_t'({8'($urandom_range(255)), 1'b1, BY_PREDICTOR, PREDICTED}));
  endfunction

  task automatic check_field(input string name, input logic [7:0] want_v,
                             input logic [7:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %h, got %h", name, want_v, got_v);
      mismatches++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // monitor: predict on each accepted request, check each accepted result
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) begin
        shunt_step(item);
        accepted = stim_q[acc_idx];
        acc_idx++;
        // hand-typed rows still move the predictor state along
        if (accepted.by_hand) begin
          postfix_q.push_back(accepted.want);
        end else begin
          foreach (step_res[k]) postfix_q.push_back(step_res[k]);
        end
      end
      if (pop && !empty) begin
        if (postfix_q.size() == 0) begin
          $error("result with nothing outstanding: out_char %h status %h",
                 result.out_char, result.status);
          mismatches++;
        end else begin
          want = postfix_q.pop_front();
          check_field("out_char", want.out_char, result.out_char);
          check_field("char_valid", 8'(want.char_valid), 8'(result.char_valid));
          check_field("last_of_expr", 8'(want.last_of_expr), 8'(result.last_of_expr));
          check_field("status", 8'(want.status), 8'(result.status));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random pop stalls per phase, one long hold-off to fill the block
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int unsigned hold_left;
    bit          held;
    hold_left = 0;
    held      = 1'b0;
    wait (!rst);
    forever begin
      @(posedge clk);
      // sender keeps offering during the hold, so full must come up
      if (phase == 2 && !held) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= ((phase == 0) ? 73 : (phase == 1) ? 36 : 0));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // main: build stimulus, reset, send requests, drain, report
  // ---------------------------------------------------------------------------
  initial begin : sender
    int unsigned i;
    int unsigned idx;
    int unsigned pick;
    int unsigned depth;
    int unsigned len;
    int unsigned max_len;
    bit          need_operand;

    for (i = 0; i < N_DIRECTED; i++) stim_q.push_back(DIRECTED[i]);

    while (stim_q.size() < N_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        // well-formed expression with random content, now and then spoiled
        depth        = 0;
        len          = 0;
        need_operand = 1'b1;
        max_len      = $urandom_range(1, 10);
        while (need_operand || len < max_len) begin
          if ($urandom_range(24) == 0) begin
            add_char(8'($urandom_range(255)));  // stray byte
          end else if (need_operand) begin
            if (depth < 18 && $urandom_range(3) == 0) begin
              add_char(CH_LPAREN);
              depth++;
            end else begin
              add_char(CH_ZERO + 8'($urandom_range(9)));
              need_operand = 1'b0;
              len++;
            end
          end else if (depth > 0 && $urandom_range(2) == 0) begin
            add_char(CH_RPAREN);
            depth--;
          end else begin
            add_char(OP_CHARS[$urandom_range(3)]);
            need_operand = 1'b1;
          end
        end
        // mostly close what is open, sometimes leave parens for the flush
        if ($urandom_range(9) != 0) repeat (depth) add_char(CH_RPAREN);
        add_end();
      end else if (pick < 82) begin
        // deep nesting of parens and operators, can run past the stack depth
        repeat ($urandom_range(12, 22)) begin
          add_char(($urandom_range(2) == 0) ? OP_CHARS[$urandom_range(3)] : CH_LPAREN);
        end
        add_char(CH_ZERO + 8'($urandom_range(9)));
        if ($urandom_range(1) == 1) add_char(CH_RPAREN);
        add_end();
      end else begin
        // noise: any byte, end marks at random
        repeat ($urandom_range(1, 6)) begin
          stim_q.push_back(stim_row_t'({8'($urandom_range(255)),
                                        1'($urandom_range(3) == 0),
                                        BY_PREDICTOR, PREDICTED}));
        end
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // one decision per cycle, so push is never lowered and raised in one step
    idx = 0;
    while (idx < stim_q.size()) begin
      @(posedge clk);
      if (push && !full) idx++;
      phase = (idx * 3 < stim_q.size()) ? 0 : (idx * 3 < 2 * stim_q.size()) ? 1 : 2;
      if (idx < stim_q.size() &&
          $urandom_range(99) >= ((phase == 0) ? 36 : (phase == 1) ? 73 : 0)) begin
        push <= 1'b1;
        item <= stim_q[idx].req;
      end else begin
        push <= 1'b0;
      end
    end

    while (postfix_q.size() != 0) @(posedge clk);
    // anything the block still sends now is an extra result
    repeat (DRAIN_CYCLES) @(posedge clk);

    // all predicted results must have come out
    if (postfix_q.size() != 0) begin
      $error("results: expected %0d more, got none", postfix_q.size());
      mismatches++;
    end

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
